// ----- rtl/bmtc_pkg.sv -----
package bmtc_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 12;
  localparam int CFG_BITS    = 8;
  localparam int THR_BITS    = SAMPLE_BITS + 2;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_CAL_DELTA     = 1'b0,
    CFG_TIMEOUT_TICKS = 1'b1
  } cfg_index_t;

  localparam logic [CFG_BITS-1:0] CAL_DELTA_RESET     = 8'd10;
  localparam logic [CFG_BITS-1:0] TIMEOUT_TICKS_RESET = 8'd20;

  // Item function codes
  typedef enum logic [2:0] {
    F_TICK      = 3'd0,
    F_OPEN      = 3'd1,
    F_CLOSE     = 3'd2,
    F_CALIBRATE = 3'd3,
    F_EMERGENCY = 3'd4
  } func_t;

  // Travel state, one-hot; bit position is the reported state code
  typedef enum logic [7:0] {
    M_OPENING   = 8'b0000_0001,
    M_CLOSING   = 8'b0000_0010,
    M_OPENED    = 8'b0000_0100,
    M_CLOSED    = 8'b0000_1000,
    M_CALUP     = 8'b0001_0000,
    M_CALSETDIR = 8'b0010_0000,
    M_CALDOWN   = 8'b0100_0000,
    M_EMERGENCY = 8'b1000_0000
  } mode_t;

  typedef enum logic [1:0] {
    D_CLOSED = 2'd0,
    D_OPENED = 2'd1,
    D_CAL    = 2'd2
  } dest_t;

  typedef struct packed {
    logic [2:0]             func;
    logic [SAMPLE_BITS-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic       motor_power;
    logic       motor_down;
    logic       signal_lamp;
    logic       is_open;
    logic [2:0] state_code;
  } out_item_t;

  // One-hot state to its 3-bit code
  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    c = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (m[i]) begin
        c = c | 3'(i);
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/barrier_motor_travel_controller_top.sv -----
// A result item is registered and is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle; the single state-update pass and the
// result register set this, and a waiting result does not block new items
// unless the result register is full and not being taken.
// Reset (rst, synchronous): state closed, destination closed, thresholds,
// counters and relay levels zero; cal_delta 10, timeout_ticks 20.
module barrier_motor_travel_controller_top #(
  parameter int TIMEOUT_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmtc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bmtc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import bmtc_pkg::*;

  localparam int CMP_BITS = (TIMEOUT_BITS > CFG_BITS) ? TIMEOUT_BITS : CFG_BITS;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_MAX = '1;

  // Configuration registers
  logic [CFG_BITS-1:0] cal_delta;
  logic [CFG_BITS-1:0] timeout_ticks;

  // Travel state
  mode_t                       mode, mode_next;
  dest_t                       dest, dest_next;
  logic signed [THR_BITS-1:0]  open_thr, open_thr_next;
  logic signed [THR_BITS-1:0]  closed_thr, closed_thr_next;
  logic [SAMPLE_BITS-1:0]      prev_sample, prev_sample_next;
  logic [TIMEOUT_BITS-1:0]     elapsed, elapsed_next;
  logic                        power, power_next;
  logic                        direction, direction_next;
  logic                        lamp, lamp_next;

  logic                        in_fire;
  logic [TIMEOUT_BITS-1:0]     elapsed_inc;
  logic                        timed_out;
  logic                        stable;
  logic [SAMPLE_BITS-1:0]      sample;
  logic [SAMPLE_BITS-1:0]      diff;
  logic signed [THR_BITS-1:0]  sample_s;
  logic signed [THR_BITS-1:0]  delta_s;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_delta     <= CAL_DELTA_RESET;
      timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CAL_DELTA:     cal_delta     <= cfg_data;
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default:           cal_delta     <= cal_delta;
      endcase
    end
  end

  // Sample arithmetic shared by the tick arms
  assign sample   = in_data.adc_sample;
  assign sample_s = signed'({2'b00, sample});
  assign delta_s  = signed'({{(THR_BITS-CFG_BITS){1'b0}}, cal_delta});
  assign diff     = (sample > prev_sample) ? sample - prev_sample : prev_sample - sample;
  assign stable   = diff < SAMPLE_BITS'(cal_delta);

  // Saturating tick count, checked after the increment
  assign elapsed_inc = (elapsed == TIMEOUT_MAX) ? elapsed : elapsed + TIMEOUT_BITS'(1);
  assign timed_out   = (CMP_BITS'(elapsed_inc) >= CMP_BITS'(timeout_ticks)) ||
                       (elapsed_inc == TIMEOUT_MAX);

  // Next state for one item
  always_comb begin
    mode_next        = mode;
    dest_next        = dest;
    open_thr_next    = open_thr;
    closed_thr_next  = closed_thr;
    prev_sample_next = prev_sample;
    elapsed_next     = elapsed;
    power_next       = power;
    direction_next   = direction;
    lamp_next        = lamp;

    case (func_t'(in_data.func))
      F_TICK: begin
        elapsed_next = elapsed_inc;
        unique case (mode)
          M_OPENING: begin
            if (sample_s > open_thr || timed_out) begin
              power_next = 1'b0;
              lamp_next  = 1'b0;
              mode_next  = M_OPENED;
            end else begin
              power_next = 1'b1;
              lamp_next  = 1'b1;
            end
          end
          M_OPENED: begin
            if (dest == D_CLOSED) begin
              elapsed_next   = '0;
              direction_next = 1'b1;
              mode_next      = M_CLOSING;
            end else if (dest == D_CAL) begin
              mode_next        = M_CALUP;
              prev_sample_next = '0;
              direction_next   = 1'b0;
              elapsed_next     = '0;
            end else begin
              direction_next = 1'b0;
            end
          end
          M_CLOSING: begin
            if (sample_s < closed_thr || timed_out) begin
              power_next = 1'b0;
              lamp_next  = 1'b0;
              mode_next  = M_CLOSED;
            end else begin
              power_next = 1'b1;
              lamp_next  = 1'b1;
            end
          end
          M_CLOSED: begin
            if (dest == D_OPENED) begin
              elapsed_next   = '0;
              direction_next = 1'b0;
              mode_next      = M_OPENING;
            end else if (dest == D_CAL) begin
              mode_next        = M_CALUP;
              prev_sample_next = '0;
              direction_next   = 1'b0;
              elapsed_next     = '0;
            end else begin
              direction_next = 1'b0;
            end
          end
          M_CALUP: begin
            dest_next        = D_CLOSED;
            prev_sample_next = sample;
            if (stable || timed_out) begin
              open_thr_next = sample_s - delta_s;
              power_next    = 1'b0;
              lamp_next     = 1'b0;
              mode_next     = M_CALSETDIR;
            end else begin
              power_next = 1'b1;
              lamp_next  = 1'b1;
            end
          end
          M_CALSETDIR: begin
            direction_next   = 1'b1;
            elapsed_next     = '0;
            prev_sample_next = '0;
            mode_next        = M_CALDOWN;
          end
          M_CALDOWN: begin
            prev_sample_next = sample;
            if (stable || timed_out) begin
              closed_thr_next = sample_s + delta_s;
              power_next      = 1'b0;
              lamp_next       = 1'b0;
              mode_next       = M_CLOSED;
            end else begin
              power_next = 1'b1;
              lamp_next  = 1'b1;
            end
          end
          M_EMERGENCY: begin
            power_next     = 1'b0;
            lamp_next      = 1'b0;
            direction_next = 1'b0;
          end
          default: begin
            mode_next = M_EMERGENCY;
          end
        endcase
      end
      F_OPEN:      dest_next = D_OPENED;
      F_CLOSE:     dest_next = D_CLOSED;
      F_CALIBRATE: dest_next = D_CAL;
      F_EMERGENCY: begin
        power_next     = 1'b0;
        lamp_next      = 1'b0;
        direction_next = 1'b0;
        mode_next      = M_EMERGENCY;
      end
      default: ;
    endcase
  end

  // State update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_CLOSED;
      dest        <= D_CLOSED;
      open_thr    <= '0;
      closed_thr  <= '0;
      prev_sample <= '0;
      elapsed     <= '0;
      power       <= 1'b0;
      direction   <= 1'b0;
      lamp        <= 1'b0;
    end else if (in_fire) begin
      mode        <= mode_next;
      dest        <= dest_next;
      open_thr    <= open_thr_next;
      closed_thr  <= closed_thr_next;
      prev_sample <= prev_sample_next;
      elapsed     <= elapsed_next;
      power       <= power_next;
      direction   <= direction_next;
      lamp        <= lamp_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.motor_power <= power_next;
      out_data.motor_down  <= direction_next;
      out_data.signal_lamp <= lamp_next;
      out_data.is_open     <= (mode_next == M_OPENED);
      out_data.state_code  <= mode_code(mode_next);
    end
  end

  // Emergency latches until reset
  a_emerg_latch: assert property (@(posedge clk) disable iff (rst)
    mode == M_EMERGENCY |=> mode == M_EMERGENCY)
    else $error("emergency state left without reset");

  // Emergency keeps every relay off
  a_emerg_off: assert property (@(posedge clk) disable iff (rst)
    mode == M_EMERGENCY && $past(in_fire) |-> !power && !direction && !lamp)
    else $error("relay on in emergency");

  // Lamp follows motor power
  a_lamp_power: assert property (@(posedge clk) disable iff (rst)
    lamp == power)
    else $error("lamp and power disagree");

  // Motor is off at rest
  a_rest_off: assert property (@(posedge clk) disable iff (rst)
    (mode == M_OPENED || mode == M_CLOSED || mode == M_CALSETDIR) |-> !power)
    else $error("motor powered at rest");

  // Every accepted item yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("result missing after accepted item");

endmodule

// ----- tb/barrier_motor_travel_controller_checker.sv -----
module barrier_motor_travel_controller_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bmtc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bmtc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output int                  failures,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmtc_pkg::*;

  localparam logic [7:0] TMO_MAX = 8'hFF;

  // Predicted controller state
  logic [CFG_BITS-1:0]        cal_delta_q;
  logic [CFG_BITS-1:0]        timeout_ticks_q;
  mode_t                      mode_q;
  dest_t                      dest_q;
  logic signed [THR_BITS-1:0] open_thr;
  logic signed [THR_BITS-1:0] closed_thr;
  logic [SAMPLE_BITS-1:0]     prev_smp;
  logic [7:0]                 elapsed;
  logic                       pwr;
  logic                       dn;
  logic                       lamp;

  out_item_t expected_outputs[$];
  out_item_t want;
  out_item_t next_out;
  int        fail_count = 0;

  assign failures = fail_count;

  task automatic clear_state();
    cal_delta_q     = CAL_DELTA_RESET;
    timeout_ticks_q = TIMEOUT_TICKS_RESET;
    mode_q          = M_CLOSED;
    dest_q          = D_CLOSED;
    open_thr        = '0;
    closed_thr      = '0;
    prev_smp        = '0;
    elapsed         = '0;
    pwr             = 1'b0;
    dn              = 1'b0;
    lamp            = 1'b0;
  endtask

  // Relay and lamp always switch together
  task automatic drive_motor(logic on);
    pwr  = on;
    lamp = on;
  endtask

  function automatic logic run_out();
    return (elapsed >= timeout_ticks_q) || (elapsed == TMO_MAX);
  endfunction

  function automatic logic settled(logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] diff;
    diff = (s > prev_smp) ? s - prev_smp : prev_smp - s;
    return diff < cal_delta_q;
  endfunction

  task automatic begin_calibration();
    mode_q   = M_CALUP;
    prev_smp = '0;
    dn       = 1'b0;
    elapsed  = '0;
  endtask

  // One interval tick of the travel state machine
  task automatic travel_tick(logic [SAMPLE_BITS-1:0] s);
    logic signed [THR_BITS-1:0] smp_s;
    logic signed [THR_BITS-1:0] delta_s;
    smp_s   = $signed({2'b00, s});
    delta_s = $signed({{(THR_BITS-CFG_BITS){1'b0}}, cal_delta_q});
    if (elapsed != TMO_MAX) begin
      elapsed = elapsed + 8'd1;
    end
    case (mode_q)
      M_OPENING: begin
        if (smp_s > open_thr || run_out()) begin
          drive_motor(1'b0);
          mode_q = M_OPENED;
        end else begin
          drive_motor(1'b1);
        end
      end
      M_OPENED: begin
        if (dest_q == D_CLOSED) begin
          elapsed = '0;
          dn      = 1'b1;
          mode_q  = M_CLOSING;
        end else if (dest_q == D_CAL) begin
          begin_calibration();
        end else begin
          dn = 1'b0;
        end
      end
      M_CLOSING: begin
        if (smp_s < closed_thr || run_out()) begin
          mode_q = M_CLOSED;
          drive_motor(1'b0);
        end else begin
          drive_motor(1'b1);
        end
      end
      M_CLOSED: begin
        if (dest_q == D_OPENED) begin
          elapsed = '0;
          dn      = 1'b0;
          mode_q  = M_OPENING;
        end else if (dest_q == D_CAL) begin
          begin_calibration();
        end else begin
          dn = 1'b0;
        end
      end
      M_CALUP: begin
        dest_q = D_CLOSED;
        drive_motor(1'b1);
        if (settled(s) || run_out()) begin
          open_thr = smp_s - delta_s;
          drive_motor(1'b0);
          mode_q = M_CALSETDIR;
        end
        prev_smp = s;
      end
      M_CALSETDIR: begin
        dn       = 1'b1;
        elapsed  = '0;
        prev_smp = '0;
        mode_q   = M_CALDOWN;
      end
      M_CALDOWN: begin
        drive_motor(1'b1);
        if (settled(s) || run_out()) begin
          closed_thr = smp_s + delta_s;
          drive_motor(1'b0);
          mode_q = M_CLOSED;
        end
        prev_smp = s;
      end
      default: begin
        drive_motor(1'b0);
        dn = 1'b0;
      end
    endcase
  endtask

  // Apply one item and report the relay levels and state after it
  task automatic predict_outputs(input in_item_t it, output out_item_t res);
    case (it.func)
      F_TICK:      travel_tick(it.adc_sample);
      F_OPEN:      dest_q = D_OPENED;
      F_CLOSE:     dest_q = D_CLOSED;
      F_CALIBRATE: dest_q = D_CAL;
      F_EMERGENCY: begin
        drive_motor(1'b0);
        dn     = 1'b0;
        mode_q = M_EMERGENCY;
      end
      default: ;  // unused codes leave everything alone
    endcase
    res.motor_power = pwr;
    res.motor_down  = dn;
    res.signal_lamp = lamp;
    res.is_open     = (mode_q == M_OPENED);
    res.state_code  = 3'($clog2(mode_q));  // one-hot bit position
  endtask

  task automatic check_field(string name, logic [2:0] want_v, logic [2:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // Sample all three channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_outputs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CAL_DELTA) begin
          cal_delta_q = cfg_data;
        end else begin
          timeout_ticks_q = cfg_data;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          fail_count++;
          $display("%0t: result with no item pending, expected none, actual %p",
                   $time, out_data);
        end else begin
          want = expected_outputs.pop_front();
          check_field("motor_power", want.motor_power, out_data.motor_power);
          check_field("motor_down", want.motor_down, out_data.motor_down);
          check_field("signal_lamp", want.signal_lamp, out_data.signal_lamp);
          check_field("is_open", want.is_open, out_data.is_open);
          check_field("state_code", want.state_code, out_data.state_code);
        end
      end
      if (in_valid && in_ready) begin
        predict_outputs(in_data, next_out);
        expected_outputs.push_back(next_out);
      end
    end
    pending = expected_outputs.size();
  end

endmodule

// ----- tb/barrier_motor_travel_controller_top_tb.sv -----
module barrier_motor_travel_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmtc_pkg::*;

  localparam int SMP_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int PHASE_LEN  = 175;
  localparam int NUM_PHASES = 6;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  int failures;
  int pending;

  always #1 clk = ~clk;

  barrier_motor_travel_controller_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  barrier_motor_travel_controller_checker travel_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  // Result side: the stall style is redrawn at random among four styles
  int rx_cycle = 0;
  int rx_style = 0;
  int rx_hold  = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) begin
      rx_style = $urandom_range(0, 3);
    end
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: begin
        if (rx_hold == 0 && $urandom_range(0, 15) == 0) begin
          rx_hold = $urandom_range(1, 12);
        end
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
      default: out_ready <= (rx_cycle % 3 == 0);
    endcase
  end

  // Run limit
  initial begin
    #500000;
    $display("simulation failed");
    $finish;
  end

  in_item_t stim[$];
  int       burst_left = 0;

  function automatic int clamp_smp(int v);
    if (v < 0) begin
      return 0;
    end
    if (v > SMP_MAX) begin
      return SMP_MAX;
    end
    return v;
  endfunction

  function automatic int rnd_smp();
    return $urandom_range(0, SMP_MAX);
  endfunction

  task automatic push(logic [2:0] f, int s);
    in_item_t it;
    it.func       = f;
    it.adc_sample = SAMPLE_BITS'(clamp_smp(s));
    stim.push_back(it);
  endtask

  // Arm travel: a run of moving samples, then a few nearly equal ones
  task automatic add_ramp(bit rising, int n);
    int v;
    int step;
    v = rising ? $urandom_range(0, 1500) : $urandom_range(2500, SMP_MAX);
    repeat (n) begin
      push(F_TICK, v);
      step = $urandom_range(0, 300);
      v = clamp_smp(rising ? v + step : v - step);
    end
    repeat ($urandom_range(1, 3)) begin
      push(F_TICK, v + int'($urandom_range(0, 4)));
    end
  endtask

  task automatic add_scenario();
    logic [2:0] f;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        push(F_CALIBRATE, rnd_smp());
        push(F_TICK, rnd_smp());
        add_ramp(1'b1, $urandom_range(1, 10));
        push(F_TICK, rnd_smp());
        add_ramp(1'b0, $urandom_range(1, 10));
      end
      3, 4: begin
        push(F_OPEN, rnd_smp());
        push(F_TICK, rnd_smp());
        add_ramp(1'b1, $urandom_range(1, 24));
      end
      5, 6: begin
        push(F_CLOSE, rnd_smp());
        push(F_TICK, rnd_smp());
        add_ramp(1'b0, $urandom_range(1, 24));
      end
      7: begin
        // new request while the arm is moving
        push(F_OPEN, rnd_smp());
        push(F_TICK, rnd_smp());
        add_ramp(1'b1, $urandom_range(1, 4));
        push(3'($urandom_range(F_OPEN, F_CALIBRATE)), rnd_smp());
        add_ramp(1'($urandom_range(0, 1)), $urandom_range(1, 8));
      end
      default: begin
        // noise, never an emergency since that latches for good
        repeat ($urandom_range(1, 6)) begin
          f = 3'($urandom_range(0, 6));
          if (f >= F_EMERGENCY) begin
            f++;
          end
          if ($urandom_range(0, 3) == 0) begin
            push(f, $urandom_range(0, 1) ? SMP_MAX : 0);
          end else begin
            push(f, rnd_smp());
          end
        end
      end
    endcase
  endtask

  // Item side: bursts of random length with random gaps
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_all();
    while (stim.size() > 0) begin
      send_item(stim.pop_front());
    end
  endtask

  // Let every result drain before going on
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] delta, logic [7:0] ticks);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CAL_DELTA;
    cfg_data  <= delta;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  logic [7:0] phase_delta [NUM_PHASES-1] = '{8'd255, 8'd0, 8'd3, 8'd40, 8'd10};
  logic [7:0] phase_ticks [NUM_PHASES-1] = '{8'd1, 8'd40, 8'd0, 8'd255, 8'd20};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ignored codes, a full calibration, open and close runs,
    // and a close request arriving while opening
    push(F_TICK, 0);
    push(3'd5, SMP_MAX);
    push(3'd6, 0);
    push(3'd7, SMP_MAX);
    push(F_CALIBRATE, 0);
    push(F_TICK, 0);
    push(F_TICK, 1000);
    push(F_TICK, 2000);
    push(F_TICK, 2005);
    push(F_TICK, 2005);
    push(F_TICK, 1500);
    push(F_TICK, 300);
    push(F_TICK, 305);
    push(F_OPEN, 0);
    push(F_TICK, 0);
    push(F_TICK, 1000);
    push(F_CLOSE, SMP_MAX);
    push(F_TICK, 2100);
    push(F_TICK, 2100);
    push(F_TICK, 1000);
    push(F_TICK, 0);
    send_all();

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p < NUM_PHASES - 1) begin
        set_config(phase_delta[p], phase_ticks[p]);
      end else begin
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      while (stim.size() < PHASE_LEN) begin
        add_scenario();
      end
      send_all();
    end

    // Emergency latch: nothing may move it afterwards
    push(F_EMERGENCY, rnd_smp());
    push(F_TICK, SMP_MAX);
    push(F_OPEN, 0);
    push(F_TICK, 0);
    push(F_CALIBRATE, rnd_smp());
    push(F_TICK, rnd_smp());
    push(F_TICK, 0);
    send_all();

    wait_idle();
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
